@@ design/htc_pkg.sv @@
// Shared types, constants and float helpers for the homogeneous triangle clipper.
`default_nettype none

package htc_pkg;

  // One vertex: x, y, z, w, u, v from the lowest bits up.
  typedef logic [5:0][31:0] vtx_t;

  localparam logic [2:0] ATTR_W    = 3'd3;
  localparam logic [2:0] ATTR_LAST = 3'd5;

  localparam logic [31:0] F_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F_ZERO        = 32'h0000_0000;

  typedef struct packed {
    vtx_t [2:0] v;
    logic       trivial;
  } tri_t;

  typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} fpu_op_t;

  typedef enum logic [1:0] {FS_IDLE, FS_DIV, FS_ROUND} fpu_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_LOAD, B_PREV_RD, B_PREV_WT, B_CUR_RD, B_CUR_WT,
    B_DP, B_DC, B_DEN, B_T, B_DIFF, B_MUL, B_ADD, B_PUSH_NV, B_KEEP,
    B_PASS_END, B_V0_RD, B_V0_WT, B_E0, B_E1, B_E2
  } back_state_t;

  function automatic logic f_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic f_is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [31:0] f_quiet(input logic [31:0] x);
    return {x[31:23], 1'b1, x[21:0]};
  endfunction

  // Multiplication by +1.0 or -1.0.
  function automatic logic [31:0] f_scale(input logic [31:0] x, input logic neg);
    logic [31:0] r;
    if (f_is_nan(x)) begin
      r = f_quiet(x);
    end else if (neg) begin
      r = {~x[31], x[30:0]};
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Ordered a <= b; false when either side is a NaN.
  function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (f_is_nan(a) || f_is_nan(b)) begin
      r = 1'b0;
    end else if (f_is_zero(a) && f_is_zero(b)) begin
      r = 1'b1;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] <= b[30:0];
    end else begin
      r = a[30:0] >= b[30:0];
    end
    return r;
  endfunction

  function automatic logic f_in_frustum(input vtx_t v);
    logic [31:0] aw;
    aw = {1'b0, v[3][30:0]};
    return f_le({1'b0, v[0][30:0]}, aw) && f_le({1'b0, v[1][30:0]}, aw) &&
           f_le({1'b0, v[2][30:0]}, aw);
  endfunction

endpackage

`default_nettype wire

@@ design/homogeneous_triangle_clipper_unit.sv @@
// Top level of the homogeneous triangle clipper.
`default_nettype none

// Vertices enter one per cycle on the slave stream; every third completes a triangle,
// which is queued (two triangles deep) for the clipping sequencer, so intake stalls only
// when both queue slots are held. A triangle wholly inside the frustum is emitted as three
// vertices without plane passes. Otherwise it goes through up to six plane passes on a
// single shared float unit, and each plane crossing takes 21 add, subtract and multiply
// steps plus a divide (skipped when the crossing denominator is zero); that unit sets the
// throughput for clipped triangles.
// A survivor of n vertices leaves as n - 2 fan triangles, three vertices each; corner
// travels on m_tuser and m_tlast marks the final vertex emitted for an input triangle.
// Rejected triangles emit nothing.
module homogeneous_triangle_clipper_unit #(
  parameter int MAX_POLY_VERTICES = 9
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [191:0] s_tdata,   // clip_x, clip_y, clip_z, clip_w, tex_u, tex_v
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [191:0]      m_tdata,   // out_x, out_y, out_z, out_w, out_u, out_v
  output logic [1:0]        m_tuser,   // corner
  output logic              m_tlast    // last_of_run
);
  import htc_pkg::*;

  logic q_valid;
  tri_t q_data;
  logic q_pop;

  htc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  htc_back #(
    .MAX_POLY_VERTICES (MAX_POLY_VERTICES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ design/htc_fpu.sv @@
// Shared single-precision unit: add, subtract, multiply and iterative divide.
`default_nettype none

module htc_fpu (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire htc_pkg::fpu_op_t op,
  input  wire logic [31:0]      a,
  input  wire logic [31:0]      b,
  output logic                  done,
  output logic [31:0]           res
);
  import htc_pkg::*;

  fpu_state_t        state, state_next;
  logic              rs;
  logic signed [11:0] re;
  logic [49:0]       rm;
  logic              spec;
  logic [31:0]       spec_val;
  logic [24:0]       rem;
  logic [23:0]       dnb;
  logic [26:0]       q;
  logic [4:0]        dcnt;

  logic              c_s;
  logic signed [11:0] c_e;
  logic [49:0]       c_m;
  logic              c_spec;
  logic [31:0]       c_spec_val;
  logic              c_div;
  logic [23:0]       c_na;
  logic [23:0]       c_nb;

  function automatic logic [5:0] lzc50(input logic [49:0] m);
    logic [5:0] c;
    logic       found;
    c = 6'd0;
    found = 1'b0;
    for (int j = 49; j >= 0; j--) begin
      if (!found) begin
        if (m[j]) begin
          found = 1'b1;
        end else begin
          c = c + 6'd1;
        end
      end
    end
    return c;
  endfunction

  // value = m * 2^(e - 176); normalize, denormalize below the range, round to even.
  function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                             input logic [49:0] m);
    logic [5:0]         lz;
    logic [49:0]        mn;
    logic signed [11:0] ex;
    logic signed [11:0] sh;
    logic [24:0]        sig;
    logic [31:0]        r;
    lz = lzc50(m);
    mn = m << lz;
    ex = e - $signed({6'd0, lz});
    if (ex < 12'sd1) begin
      sh = 12'sd1 - ex;
      if (sh >= 12'sd50) begin
        mn = {49'd0, |mn};
      end else begin
        mn = (mn >> sh[5:0]) | {49'd0, |(mn & ~({50{1'b1}} << sh[5:0]))};
      end
      ex = 12'sd1;
    end
    sig = {1'b0, mn[49:26]};
    if (mn[25] && ((|mn[24:0]) || sig[0])) begin
      sig = sig + 25'd1;
    end
    if (sig[24]) begin
      sig = sig >> 1;
      ex = ex + 12'sd1;
    end
    if (m == 50'd0) begin
      r = {s, 31'd0};
    end else if (ex >= 12'sd255) begin
      r = {s, 8'hFF, 23'd0};
    end else begin
      r = {s, sig[23] ? ex[7:0] : 8'd0, sig[22:0]};
    end
    return r;
  endfunction

  always_comb begin
    logic [31:0] bb;
    logic [23:0] sa;
    logic [23:0] sb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [47:0] p;
    logic        a_big;
    logic [23:0] sig_big;
    logic [23:0] sig_sm;
    logic [7:0]  e_big;
    logic [7:0]  e_sm;
    logic [7:0]  d;
    logic [49:0] mb;
    logic [49:0] ms0;
    logic [49:0] ms;
    logic        s_big;
    logic        s_sm;
    logic [5:0]  lza;
    logic [5:0]  lzb;
    bb = (op == FOP_SUB && !f_is_nan(b)) ? {~b[31], b[30:0]} : b;
    sa = {a[30:23] != 8'd0, a[22:0]};
    sb = {bb[30:23] != 8'd0, bb[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (bb[30:23] == 8'd0) ? 8'd1 : bb[30:23];
    p = sa * sb;
    a_big = a[30:0] >= bb[30:0];
    sig_big = a_big ? sa : sb;
    sig_sm = a_big ? sb : sa;
    e_big = a_big ? ea : eb;
    e_sm = a_big ? eb : ea;
    s_big = a_big ? a[31] : bb[31];
    s_sm = a_big ? bb[31] : a[31];
    d = e_big - e_sm;
    mb = {1'b0, sig_big, 25'd0};
    ms0 = {1'b0, sig_sm, 25'd0};
    if (d >= 8'd50) begin
      ms = {49'd0, |ms0};
    end else begin
      ms = (ms0 >> d[5:0]) | {49'd0, |(ms0 & ~({50{1'b1}} << d[5:0]))};
    end
    lza = lzc50({sa, 26'd0});
    lzb = lzc50({sb, 26'd0});
    c_s = a[31] ^ bb[31];
    c_e = 12'sd0;
    c_m = 50'd0;
    c_spec = 1'b0;
    c_spec_val = F_ZERO;
    c_div = 1'b0;
    c_na = sa << lza;
    c_nb = sb << lzb;
    if (f_is_nan(a)) begin
      c_spec = 1'b1;
      c_spec_val = f_quiet(a);
    end else if (f_is_nan(bb)) begin
      c_spec = 1'b1;
      c_spec_val = f_quiet(bb);
    end else begin
      case (op)
        FOP_ADD, FOP_SUB: begin
          if (f_is_inf(a) && f_is_inf(bb) && (a[31] != bb[31])) begin
            c_spec = 1'b1;
            c_spec_val = F_DEFAULT_NAN;
          end else if (f_is_inf(a)) begin
            c_spec = 1'b1;
            c_spec_val = a;
          end else if (f_is_inf(bb)) begin
            c_spec = 1'b1;
            c_spec_val = bb;
          end else begin
            c_m = (s_big == s_sm) ? mb + ms : mb - ms;
            c_e = $signed({4'd0, e_big}) + 12'sd1;
            c_s = (c_m == 50'd0) ? (a[31] & bb[31]) : s_big;
          end
        end
        FOP_MUL: begin
          if ((f_is_inf(a) && f_is_zero(bb)) || (f_is_zero(a) && f_is_inf(bb))) begin
            c_spec = 1'b1;
            c_spec_val = F_DEFAULT_NAN;
          end else if (f_is_inf(a) || f_is_inf(bb)) begin
            c_spec = 1'b1;
            c_spec_val = {c_s, 8'hFF, 23'd0};
          end else begin
            c_m = {p, 2'b00};
            c_e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
          end
        end
        FOP_DIV: begin
          if ((f_is_inf(a) && f_is_inf(bb)) || (f_is_zero(a) && f_is_zero(bb))) begin
            c_spec = 1'b1;
            c_spec_val = F_DEFAULT_NAN;
          end else if (f_is_inf(a) || f_is_zero(bb)) begin
            c_spec = 1'b1;
            c_spec_val = {c_s, 8'hFF, 23'd0};
          end else if (f_is_inf(bb) || f_is_zero(a)) begin
            c_spec = 1'b1;
            c_spec_val = {c_s, 31'd0};
          end else begin
            c_div = 1'b1;
            c_e = $signed({4'd0, ea}) - $signed({6'd0, lza}) - $signed({4'd0, eb}) +
                  $signed({6'd0, lzb}) + 12'sd127;
          end
        end
        default: begin
          c_spec = 1'b1;
          c_spec_val = F_DEFAULT_NAN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: begin
        if (start) begin
          state_next = c_div ? FS_DIV : FS_ROUND;
        end
      end
      FS_DIV: begin
        if (dcnt == 5'd26) begin
          state_next = FS_ROUND;
        end
      end
      FS_ROUND: state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == FS_ROUND);
    end
  end

  // Restoring divide: one quotient bit per cycle, 27 bits in all.
  always_ff @(posedge clk) begin
    case (state)
      FS_IDLE: begin
        if (start) begin
          rs <= c_s;
          re <= c_e;
          rm <= c_m;
          spec <= c_spec;
          spec_val <= c_spec_val;
          rem <= {1'b0, c_na};
          dnb <= c_nb;
          q <= 27'd0;
          dcnt <= 5'd0;
        end
      end
      FS_DIV: begin
        if (rem >= {1'b0, dnb}) begin
          rem <= (rem - {1'b0, dnb}) << 1;
          q <= {q[25:0], 1'b1};
        end else begin
          rem <= rem << 1;
          q <= {q[25:0], 1'b0};
        end
        dcnt <= dcnt + 5'd1;
        if (dcnt == 5'd26) begin
          rm <= {q[25:0], rem >= {1'b0, dnb}, 1'b0, 22'd0} |
                {27'd0, (rem >= {1'b0, dnb}) ? (rem != {1'b0, dnb}) : (rem != 25'd0), 22'd0};
        end
      end
      FS_ROUND: begin
        res <= spec ? spec_val : round_pack(rs, re, rm);
      end
      default: begin
      end
    endcase
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("fpu done held longer than one cycle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == FS_DIV) |=> (state == FS_DIV || state == FS_ROUND))
    else $error("divide left without rounding");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == FS_DIV) |-> dcnt <= 5'd26)
    else $error("divide count overran");

endmodule

`default_nettype wire

@@ design/htc_front.sv @@
// Vertex intake: gathers three vertices, flags trivially accepted triangles, queues them.
`default_nettype none

module htc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [191:0]  s_tdata,
  output logic               q_valid,
  output htc_pkg::tri_t      q_data,
  input  wire logic          q_pop
);
  import htc_pkg::*;

  vtx_t       v0;
  vtx_t       v1;
  logic [1:0] ins;
  logic [1:0] loaded;
  tri_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] qcount;
  logic       acc;
  logic       push;
  vtx_t       vin;

  assign vin = s_tdata;
  assign s_tready = (loaded != 2'd2) || (qcount != 2'd2);
  assign acc = s_tvalid && s_tready;
  assign push = acc && (loaded == 2'd2);
  assign q_valid = qcount != 2'd0;
  assign q_data = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
      qcount <= 2'd0;
    end else begin
      if (acc) begin
        loaded <= (loaded == 2'd2) ? 2'd0 : loaded + 2'd1;
      end
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      qcount <= qcount + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (acc && loaded == 2'd0) begin
      v0 <= vin;
      ins[0] <= f_in_frustum(vin);
    end
    if (acc && loaded == 2'd1) begin
      v1 <= vin;
      ins[1] <= f_in_frustum(vin);
    end
    if (push) begin
      q[wptr] <= '{v: '{vin, v1, v0}, trivial: ins[0] && ins[1] && f_in_frustum(vin)};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> qcount != 2'd2)
    else $error("triangle queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) qcount <= 2'd2)
    else $error("triangle queue count out of range");

endmodule

`default_nettype wire

@@ design/htc_back.sv @@
// Clipping sequencer: plane passes over two vertex buffers, then fan emission.
`default_nettype none

module htc_back #(
  parameter int MAX_POLY_VERTICES = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire htc_pkg::tri_t q_data,
  output logic               q_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [191:0]       m_tdata,
  output logic [1:0]         m_tuser,
  output logic               m_tlast
);
  import htc_pkg::*;

  localparam int IW = $clog2(MAX_POLY_VERTICES);
  localparam int CW = $clog2(MAX_POLY_VERTICES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_POLY_VERTICES);

  back_state_t state, state_next;
  tri_t        tri_r;
  logic [1:0]  axis;
  logic        neg;
  logic [CW-1:0] n;
  logic [CW-1:0] cnt;
  logic [CW-1:0] i;
  logic [2:0]  k;
  vtx_t        prev;
  vtx_t        cur;
  vtx_t        nv;
  vtx_t        v0;
  logic [31:0] pc;
  logic [31:0] cc;
  logic        pin;
  logic        cin;
  logic [31:0] dp;
  logic [31:0] dc;
  logic [31:0] den;
  logic [31:0] t;
  logic [31:0] diff;
  logic [31:0] prod;
  logic        fpu_busy;

  vtx_t        mem0 [MAX_POLY_VERTICES];
  vtx_t        mem1 [MAX_POLY_VERTICES];
  vtx_t        rdata0;
  vtx_t        rdata1;
  vtx_t        src_rdata;
  logic        rd_en0;
  logic        rd_en1;
  logic [IW-1:0] rd_addr;
  logic        wr_en0;
  logic        wr_en1;
  logic [IW-1:0] wr_addr;
  vtx_t        wr_data;

  logic        fpu_start;
  fpu_op_t     fpu_op;
  logic [31:0] fpu_a;
  logic [31:0] fpu_b;
  logic        fpu_done;
  logic [31:0] fpu_res;
  logic        fpu_state;
  logic        out_free;
  logic        out_load;
  vtx_t        out_v;
  logic [1:0]  out_corner;
  logic        out_last;
  logic [31:0] rd_comp;
  logic        rd_in;

  htc_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (fpu_start),
    .op    (fpu_op),
    .a     (fpu_a),
    .b     (fpu_b),
    .done  (fpu_done),
    .res   (fpu_res)
  );

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem0[wr_addr] <= wr_data;
    end
    if (rd_en0) begin
      rdata0 <= mem0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en1) begin
      mem1[wr_addr] <= wr_data;
    end
    if (rd_en1) begin
      rdata1 <= mem1[rd_addr];
    end
  end

  assign src_rdata = neg ? rdata1 : rdata0;
  assign rd_comp = f_scale(src_rdata[{1'b0, axis}], neg);
  assign rd_in = f_le(rd_comp, src_rdata[ATTR_W]);
  assign out_free = !m_tvalid || m_tready;
  assign fpu_state = (state == B_DP) || (state == B_DC) || (state == B_DEN) ||
                     (state == B_T) || (state == B_DIFF) || (state == B_MUL) ||
                     (state == B_ADD);
  assign fpu_start = fpu_state && !fpu_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    rd_en0 = 1'b0;
    rd_en1 = 1'b0;
    rd_addr = '0;
    wr_en0 = 1'b0;
    wr_en1 = 1'b0;
    wr_addr = cnt[IW-1:0];
    wr_data = cur;
    fpu_op = FOP_SUB;
    fpu_a = prev[ATTR_W];
    fpu_b = pc;
    out_load = 1'b0;
    out_v = v0;
    out_corner = 2'd0;
    out_last = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = B_LOAD;
        end
      end
      B_LOAD: begin
        wr_en0 = 1'b1;
        wr_addr = i[IW-1:0];
        wr_data = tri_r.v[i[1:0]];
        if (i == CW'(2)) begin
          state_next = tri_r.trivial ? B_V0_RD : B_PREV_RD;
        end
      end
      B_PREV_RD: begin
        rd_en0 = !neg;
        rd_en1 = neg;
        rd_addr = IW'(n - CW'(1));
        state_next = B_PREV_WT;
      end
      B_PREV_WT: state_next = B_CUR_RD;
      B_CUR_RD: begin
        rd_en0 = !neg;
        rd_en1 = neg;
        rd_addr = i[IW-1:0];
        state_next = B_CUR_WT;
      end
      B_CUR_WT: state_next = (rd_in != pin) ? B_DP : B_KEEP;
      B_DP: begin
        if (fpu_done) begin
          state_next = B_DC;
        end
      end
      B_DC: begin
        fpu_a = cur[ATTR_W];
        fpu_b = cc;
        if (fpu_done) begin
          state_next = B_DEN;
        end
      end
      B_DEN: begin
        fpu_a = dp;
        fpu_b = dc;
        if (fpu_done) begin
          state_next = f_is_zero(fpu_res) ? B_DIFF : B_T;
        end
      end
      B_T: begin
        fpu_op = FOP_DIV;
        fpu_a = dp;
        fpu_b = den;
        if (fpu_done) begin
          state_next = B_DIFF;
        end
      end
      B_DIFF: begin
        fpu_a = cur[k];
        fpu_b = prev[k];
        if (fpu_done) begin
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        fpu_op = FOP_MUL;
        fpu_a = diff;
        fpu_b = t;
        if (fpu_done) begin
          state_next = B_ADD;
        end
      end
      B_ADD: begin
        fpu_op = FOP_ADD;
        fpu_a = prev[k];
        fpu_b = prod;
        if (fpu_done) begin
          state_next = (k == ATTR_LAST) ? B_PUSH_NV : B_DIFF;
        end
      end
      B_PUSH_NV: begin
        wr_en0 = neg && (cnt < MAXC);
        wr_en1 = !neg && (cnt < MAXC);
        wr_data = nv;
        state_next = B_KEEP;
      end
      B_KEEP: begin
        wr_en0 = neg && cin && (cnt < MAXC);
        wr_en1 = !neg && cin && (cnt < MAXC);
        state_next = (i == n - CW'(1)) ? B_PASS_END : B_CUR_RD;
      end
      B_PASS_END: begin
        if (cnt == '0) begin
          state_next = B_IDLE;
        end else if (neg && axis == 2'd2) begin
          state_next = (cnt < CW'(3)) ? B_IDLE : B_V0_RD;
        end else begin
          state_next = B_PREV_RD;
        end
      end
      B_V0_RD: begin
        rd_en0 = 1'b1;
        rd_addr = '0;
        state_next = B_V0_WT;
      end
      B_V0_WT: state_next = B_E0;
      B_E0: begin
        if (out_free) begin
          out_load = 1'b1;
          rd_en0 = 1'b1;
          rd_addr = i[IW-1:0];
          state_next = B_E1;
        end
      end
      B_E1: begin
        if (out_free) begin
          out_load = 1'b1;
          out_v = rdata0;
          out_corner = 2'd1;
          rd_en0 = 1'b1;
          rd_addr = IW'(i + CW'(1));
          state_next = B_E2;
        end
      end
      B_E2: begin
        if (out_free) begin
          out_load = 1'b1;
          out_v = rdata0;
          out_corner = 2'd2;
          out_last = (i + CW'(2)) == n;
          state_next = out_last ? B_IDLE : B_E0;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fpu_busy <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (fpu_start) begin
        fpu_busy <= 1'b1;
      end else if (fpu_done) begin
        fpu_busy <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_v;
      m_tuser <= out_corner;
      m_tlast <= out_last;
    end
    case (state)
      B_IDLE: begin
        tri_r <= q_data;
        i <= '0;
        axis <= 2'd0;
        neg <= 1'b0;
      end
      B_LOAD: begin
        i <= i + CW'(1);
        n <= CW'(3);
      end
      B_PREV_WT: begin
        prev <= src_rdata;
        pc <= rd_comp;
        pin <= rd_in;
        i <= '0;
        cnt <= '0;
      end
      B_CUR_WT: begin
        cur <= src_rdata;
        cc <= rd_comp;
        cin <= rd_in;
      end
      B_DP: if (fpu_done) dp <= fpu_res;
      B_DC: if (fpu_done) dc <= fpu_res;
      B_DEN: begin
        if (fpu_done) begin
          den <= fpu_res;
          t <= F_ZERO;
          k <= 3'd0;
        end
      end
      B_T: if (fpu_done) t <= fpu_res;
      B_DIFF: if (fpu_done) diff <= fpu_res;
      B_MUL: if (fpu_done) prod <= fpu_res;
      B_ADD: begin
        if (fpu_done) begin
          nv[k] <= fpu_res;
          k <= k + 3'd1;
        end
      end
      B_PUSH_NV: if (cnt < MAXC) cnt <= cnt + CW'(1);
      B_KEEP: begin
        if (cin && cnt < MAXC) begin
          cnt <= cnt + CW'(1);
        end
        prev <= cur;
        pc <= cc;
        pin <= cin;
        i <= i + CW'(1);
      end
      B_PASS_END: begin
        n <= cnt;
        neg <= ~neg;
        if (neg) begin
          axis <= axis + 2'd1;
        end
      end
      B_V0_WT: begin
        v0 <= rdata0;
        i <= CW'(1);
      end
      B_E2: if (out_free) i <= i + CW'(1);
      default: begin
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_PASS_END) |-> cnt <= MAXC)
    else $error("polygon count beyond buffer depth");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty triangle queue");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) fpu_done |-> fpu_busy)
    else $error("float result with no operation pending");

endmodule

`default_nettype wire
